// ===== hdl/ccf_pkg.sv =====
// Package for the colour filter chain: widths, operation codes, coefficient tables,
// the per-stage coefficient builder and the pixel struct handed along the chain.
// No dependencies.
package ccf_pkg;

	localparam int NUM_STAGES = 4;
	localparam int REG_COUNT  = 4;
	localparam int SET_W      = 52;
	localparam int COEF_W     = 36;
	localparam int ACC_W      = 48;
	localparam int UNIT_Q12   = 4096;

	localparam logic [3:0] OP_PASS   = 4'd0;
	localparam logic [3:0] OP_GRAY   = 4'd1;
	localparam logic [3:0] OP_BRIGHT = 4'd2;
	localparam logic [3:0] OP_CONTR  = 4'd3;
	localparam logic [3:0] OP_SEPIA  = 4'd4;
	localparam logic [3:0] OP_HUE    = 4'd5;
	localparam logic [3:0] OP_INVERT = 4'd6;
	localparam logic [3:0] OP_SAT    = 4'd7;
	localparam logic [3:0] OP_OPAC   = 4'd8;

	localparam int LUMA [3] = '{13933, 46871, 4732};
	localparam int SEPIA [9] = '{25756, 50397, 12386, 22872, 44958, 11010,
		17826, 34996, 8585};
	localparam int HUE_K0 [9] = '{3490, 11715, 1180, 3490, 11715, 1180,
		3490, 11715, 1180};
	localparam int HUE_KC [9] = '{12894, -11715, -1180, -3490, 4669, -1180,
		-3490, -11715, 15204};
	localparam int HUE_KS [9] = '{-3490, -11715, 15204, 2343, 2294, -4637,
		-12894, 11715, 1180};
	localparam int SAT_K [9] = '{12894, -11715, -1180, -3490, 4669, -1180,
		-3490, -11715, 15204};

	typedef logic signed [COEF_W-1:0] coef_w_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	// Each stage is reduced to res_i = round(sum_j m_ij * c_j + off_i) in Q28.
	typedef struct packed {
		coef_w_t [8:0] m;
		acc_t [2:0]    off;
		logic          opa;
		logic [12:0]   cu;
	} coef_t;

	typedef struct packed {
		logic            valid;
		logic [7:0]      a;
		logic [2:0][7:0] ch;
	} pix_t;

	function automatic coef_t stage_coef(input logic [SET_W-1:0] s);
		coef_t r;
		logic [3:0] op;
		acc_t amt;
		acc_t cu;
		acc_t cs;
		acc_t sn;
		acc_t one;
		acc_t v;
		op  = s[3:0];
		amt = $signed({32'd0, s[19:4]});
		cu  = (amt > acc_t'(UNIT_Q12)) ? acc_t'(UNIT_Q12) : amt;
		cs  = $signed({{32{s[35]}}, s[35:20]});
		sn  = $signed({{32{s[51]}}, s[51:36]});
		one = acc_t'(1) <<< 28;
		for (int i = 0; i < 3; i++) begin
			r.off[i] = '0;
			for (int j = 0; j < 3; j++) begin
				r.m[i*3+j] = (i == j) ? COEF_W'(one) : '0;
			end
		end
		r.opa = 1'b0;
		r.cu  = cu[12:0];
		case (op)
			OP_GRAY, OP_SEPIA: begin
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						v = cu * acc_t'((op == OP_GRAY) ? LUMA[j] : SEPIA[i*3+j]);
						if (i == j) v = v + one - (cu <<< 16);
						r.m[i*3+j] = COEF_W'(v);
					end
				end
			end
			OP_BRIGHT: begin
				for (int i = 0; i < 3; i++) r.m[i*4] = COEF_W'(amt <<< 16);
			end
			OP_CONTR: begin
				for (int i = 0; i < 3; i++) begin
					r.m[i*4] = COEF_W'(amt <<< 16);
					r.off[i] = (acc_t'(255 * UNIT_Q12) - acc_t'(255) * amt) <<< 15;
				end
			end
			OP_HUE: begin
				for (int k = 0; k < 9; k++) begin
					v = (acc_t'(HUE_K0[k]) <<< 14) + acc_t'(HUE_KC[k]) * cs
						+ acc_t'(HUE_KS[k]) * sn;
					r.m[k] = COEF_W'(v);
				end
			end
			OP_INVERT: begin
				for (int i = 0; i < 3; i++) begin
					r.m[i*4] = COEF_W'((acc_t'(UNIT_Q12) - (cu <<< 1)) <<< 16);
					r.off[i] = (acc_t'(255) * cu) <<< 16;
				end
			end
			OP_SAT: begin
				for (int k = 0; k < 9; k++) begin
					v = ((acc_t'(HUE_K0[k]) <<< 12) + acc_t'(SAT_K[k]) * amt) <<< 2;
					r.m[k] = COEF_W'(v);
				end
			end
			OP_OPAC: r.opa = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/ccf_cell.sv =====
// One filter stage of the chain: a 3x3 matrix with offset, two pipeline registers.
// Depends on ccf_pkg.
module ccf_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [ccf_pkg::SET_W-1:0] setting,
	input  ccf_pkg::pix_t            pix_in,
	output ccf_pkg::pix_t            pix_out
);
	import ccf_pkg::*;

	coef_t           coef_q;
	acc_t [8:0]      prod_s1;
	logic [20:0]     aprod_s1;
	logic            valid_s1;
	logic [7:0]      a_s1;
	logic            valid_s2;
	logic [7:0]      a_s2;
	logic [2:0][7:0] ch_s2;

	// Coefficients are loaded at the same edge as the setting register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) coef_q <= stage_coef('0);
		else coef_q <= stage_coef(setting);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= pix_in.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				prod_s1[k] <= ACC_W'(coef_q.m[k]) * $signed({40'd0, pix_in.ch[k%3]});
			end
			aprod_s1 <= 21'(pix_in.a) * 21'(coef_q.cu);
			a_s1     <= pix_in.a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		acc_t t;
		logic [20:0] ta;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				t = prod_s1[i*3] + prod_s1[i*3+1] + prod_s1[i*3+2] + coef_q.off[i]
					+ (acc_t'(1) <<< 27);
				if (t < 0) ch_s2[i] <= 8'd0;
				else if ((t >>> 28) > acc_t'(255)) ch_s2[i] <= 8'd255;
				else ch_s2[i] <= t[35:28];
			end
			ta = aprod_s1 + 21'd2048;
			a_s2 <= coef_q.opa ? ta[19:12] : a_s1;
		end
	end

	assign pix_out = {valid_s2, a_s2, ch_s2};

endmodule

// ===== hdl/ccf_premul.sv =====
// Final cell: premultiplies RGB by alpha when alpha is below full, two pipeline registers.
// Depends on ccf_pkg.
module ccf_premul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  ccf_pkg::pix_t pix_in,
	output ccf_pkg::pix_t pix_out
);
	import ccf_pkg::*;

	logic [2:0][15:0] prod_s1;
	logic [2:0][7:0]  ch_s1;
	logic [7:0]       a_s1;
	logic             valid_s1;
	logic             valid_s2;
	logic [7:0]       a_s2;
	logic [2:0][7:0]  ch_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pix_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic [16:0] x;
		logic [16:0] q;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= 16'(pix_in.ch[i]) * 16'(pix_in.a);
			end
			ch_s1 <= pix_in.ch;
			a_s1  <= pix_in.a;
			// Division by 255 as a shift-and-add, exact for the products that occur.
			for (int i = 0; i < 3; i++) begin
				x = 17'(prod_s1[i]) + 17'd127;
				q = (x + (x >> 8) + 17'd1) >> 8;
				ch_s2[i] <= (a_s1 == 8'd255) ? ch_s1[i] : q[7:0];
			end
			a_s2 <= a_s1;
		end
	end

	assign pix_out = {valid_s2, a_s2, ch_s2};

endmodule

// ===== hdl/css_color_filter_chain.sv =====
// Top level of the colour filter chain: configuration port, row of filter cells, premultiply.
// Depends on ccf_pkg, ccf_cell and ccf_premul.
// Pipeline: two registers per cell.
// Throughput: one pixel per clock; the whole row advances together and holds while the
// output transfer is stalled.
// Reset: arst_n clears the stage settings to pass and empties the pipeline.
module css_color_filter_chain (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // pixel_abgr_in [31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // pixel_abgr_out [31:0]
);
	import ccf_pkg::*;

	logic [REG_COUNT-1:0][SET_W-1:0] set_q;
	logic [REG_COUNT-1:0][SET_W-1:0] set_d;
	pix_t [NUM_STAGES:0]             link;
	pix_t                            out_pix;
	logic                            en;

	// The cells see the next register value so their coefficients are ready for the
	// first transfer after a write.
	always_comb begin
		set_d = set_q;
		if (psel && penable && pwrite) set_d[paddr[4:3]] = pwdata[SET_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) set_q <= '0;
		else set_q <= set_d;
	end

	assign prdata = {12'd0, set_q[paddr[4:3]]};
	assign pready = 1'b1;

	assign en       = !out_pix.valid || m_tready;
	assign s_tready = en;

	assign link[0] = {s_tvalid, s_tdata};

	for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
		ccf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.setting ((g < REG_COUNT) ? set_d[g % REG_COUNT] : {SET_W{1'b0}}),
			.pix_in  (link[g]),
			.pix_out (link[g+1])
		);
	end

	ccf_premul u_premul (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.pix_in  (link[NUM_STAGES]),
		.pix_out (out_pix)
	);

	assign m_tvalid = out_pix.valid;
	assign m_tdata  = {out_pix.a, out_pix.ch};

endmodule
